>>> rtl/tmmu_pkg.sv
package tmmu_pkg;

  localparam int unsigned TLB_ENTRIES_DEF   = 4;
  localparam int unsigned TABLE_ENTRIES_DEF = 32;

  // command codes
  localparam logic [1:0] CMD_TRANSLATE  = 2'd0;
  localparam logic [1:0] CMD_RESPONSE   = 2'd1;
  localparam logic [1:0] CMD_INVALIDATE = 2'd2;

  // result kinds
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // flag and request bit positions
  localparam int unsigned FLAG_SUPER_BIT  = 3;
  localparam int unsigned FLAG_ACTIVE_BIT = 7;
  localparam int unsigned PAGE_SHIFT      = 16;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] virtual_address;
    logic [3:0]  access_request;
    logic [31:0] entry_word;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic        allowed;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
  } dp_sts_t;

endpackage

>>> rtl/tlb_mmu_with_table_walk.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o    in_data_i  (command, address, access, word)
// out      output     out_valid_o / out_ready_i  out_data_o (kind, address, allowed)
// cfg      input      cfg_we_i, no wait          cfg_wdata_i (table base)
//
// Each item passes the transfer (idle) state, then the execute state in which
// the TLB compare or the table word check runs; the next item is taken only
// once execute ends, so no new item is accepted while one is in execute.
// A result held in the output register does not block input; only an item
// that makes a result while that register is still full waits in execute.
// Reset clears the valid flags, the walk state and the table base; no sweep.
module tlb_mmu_with_table_walk #(
  parameter int unsigned TLB_ENTRIES   = tmmu_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned TABLE_ENTRIES = tmmu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmmu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmmu_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);
  import tmmu_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencing: accept, execute, hand result to the output register
  tmmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  // TLB, walk state, access check and output register
  tmmu_dp #(
    .TLB_ENTRIES   (TLB_ENTRIES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts)
  );

endmodule

>>> rtl/tmmu_ctrl.sv
module tmmu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tmmu_pkg::dp_cmd_t cmd_o,
  input  tmmu_pkg::dp_sts_t sts_i
);
  import tmmu_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a result waits here until the output register can take it
        if (!sts_i.has_result || out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit && sts_i.has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/tmmu_dp.sv
module tmmu_dp #(
  parameter int unsigned TLB_ENTRIES   = tmmu_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned TABLE_ENTRIES = tmmu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  tmmu_pkg::in_item_t  in_data_i,
  output tmmu_pkg::out_item_t out_data_o,
  input  tmmu_pkg::dp_cmd_t   cmd_i,
  output tmmu_pkg::dp_sts_t   sts_o
);
  import tmmu_pkg::*;

  localparam int unsigned VW = $clog2(TLB_ENTRIES);
  localparam int unsigned WW = $clog2(TABLE_ENTRIES + 1);

  in_item_t  item_q;
  out_item_t out_q, res;
  logic [31:0] base_q;

  logic [7:0]  tlb_vp_q [TLB_ENTRIES];
  logic [15:0] tlb_pp_q [TLB_ENTRIES];
  logic [7:0]  tlb_fl_q [TLB_ENTRIES];

  logic [VW-1:0] victim_q;
  logic [WW-1:0] widx_q;
  logic          pend_q;
  logic [31:0]   paddr_q;
  logic [3:0]    pacc_q;

  logic [TLB_ENTRIES-1:0] match, first;
  logic [15:0] hit_pp;
  logic [7:0]  hit_fl;
  logic        hit;
  logic [7:0]  req_vp, pend_vp, w_vp, w_fl;
  logic [15:0] w_pp;
  logic        w_match;
  logic [WW-1:0] idx_inc;
  logic          last;
  logic [31:0]   rd_addr;
  logic          has_result;

  function automatic logic access_ok(logic [7:0] fl, logic [3:0] req);
    if (req[FLAG_SUPER_BIT]) return 1'b1;
    if (fl[FLAG_SUPER_BIT]) return 1'b0;
    return req[2:0] == fl[2:0];
  endfunction

  function automatic out_item_t finish(logic [7:0] fl, logic [15:0] pp,
                                       logic [31:0] va, logic [3:0] req);
    out_item_t r;
    r.kind = KIND_DONE;
    if (access_ok(fl, req)) begin
      r.address = {pp, va[PAGE_SHIFT-1:0]};
      r.allowed = 1'b1;
    end else begin
      r.address = va;
      r.allowed = 1'b0;
    end
    return r;
  endfunction

  // TLB search, lowest matching entry wins
  assign req_vp = item_q.virtual_address[23:16];

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = tlb_fl_q[i][FLAG_ACTIVE_BIT] && (tlb_vp_q[i] == req_vp);
    end
  end

  assign first = match & (~match + TLB_ENTRIES'(1));
  assign hit   = |match;

  always_comb begin
    hit_pp = '0;
    hit_fl = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_pp = hit_pp | ({16{first[i]}} & tlb_pp_q[i]);
      hit_fl = hit_fl | ({8{first[i]}} & tlb_fl_q[i]);
    end
  end

  // table word check
  assign pend_vp = paddr_q[23:16];
  assign w_vp    = item_q.entry_word[7:0];
  assign w_fl    = item_q.entry_word[15:8];
  assign w_pp    = item_q.entry_word[31:16];
  assign w_match = (w_vp == pend_vp) && w_fl[FLAG_ACTIVE_BIT];
  assign idx_inc = widx_q + WW'(1);
  assign last    = (idx_inc == WW'(TABLE_ENTRIES));
  assign rd_addr = base_q + (32'(idx_inc) << 2);

  always_comb begin
    has_result  = 1'b0;
    res.kind    = KIND_DONE;
    res.address = item_q.virtual_address;
    res.allowed = 1'b0;
    case (item_q.command)
      CMD_TRANSLATE: begin
        has_result = 1'b1;
        if (base_q == '0) begin
          res.allowed = 1'b1;
        end else if (hit) begin
          res = finish(hit_fl, hit_pp, item_q.virtual_address, item_q.access_request);
        end else begin
          res.kind    = KIND_READ;
          res.address = base_q;
        end
      end
      CMD_RESPONSE: begin
        if (pend_q) begin
          has_result = 1'b1;
          if (w_match) begin
            res = finish(w_fl, w_pp, paddr_q, pacc_q);
          end else if (last) begin
            res.address = paddr_q;
          end else begin
            res.kind    = KIND_READ;
            res.address = rd_addr;
          end
        end
      end
      default: has_result = 1'b0;
    endcase
  end

  assign sts_o.has_result = has_result;

  // item and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.commit && has_result) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // TLB pages, no reset: only read behind an active flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (item_q.command == CMD_RESPONSE) && pend_q && w_match) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (victim_q == VW'(i)) begin
          tlb_vp_q[i] <= pend_vp;
          tlb_pp_q[i] <= w_pp;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_fl_q[i] <= '0;
      end
      victim_q <= '0;
      widx_q   <= '0;
      pend_q   <= 1'b0;
      paddr_q  <= '0;
      pacc_q   <= '0;
    end else if (cmd_i.commit) begin
      case (item_q.command)
        CMD_TRANSLATE: begin
          pend_q <= 1'b0;
          if ((base_q != '0) && !hit) begin
            pend_q  <= 1'b1;
            widx_q  <= '0;
            paddr_q <= item_q.virtual_address;
            pacc_q  <= item_q.access_request;
          end
        end
        CMD_RESPONSE: begin
          if (pend_q) begin
            if (w_match) begin
              for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (victim_q == VW'(i)) begin
                  tlb_fl_q[i] <= w_fl;
                end
              end
              victim_q <= (victim_q == VW'(TLB_ENTRIES - 1)) ? '0 : victim_q + VW'(1);
              pend_q   <= 1'b0;
            end else begin
              widx_q <= idx_inc;
              if (last) begin
                pend_q <= 1'b0;
              end
            end
          end
        end
        CMD_INVALIDATE: begin
          for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_fl_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
